@@ rtl/block_rms_level_meter_macros.svh @@
// assertion helpers shared by the rtl files of the rms level meter
`ifndef BLOCK_RMS_LEVEL_METER_MACROS_SVH
`define BLOCK_RMS_LEVEL_METER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BRLM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BRLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/brlm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlm_pkg
// types and fixed constants of the block rms level meter
// ----------------------------------------------------------------------------
package brlm_pkg;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 10;
    localparam int BLOCK_W    = 16;
    localparam int SCALE_W    = 10;
    localparam int DZ_W       = 15;
    localparam int ZCOUNT_W   = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = 2'd2;

    // reset values
    localparam logic [BLOCK_W-1:0]        BLOCK_SIZE_RST = 16'd11025;
    localparam logic [SCALE_W-1:0]        SCALE_RST      = 10'd100;
    localparam logic [DZ_W-1:0]           DEAD_ZONE_RST  = 15'd0;
    localparam logic signed [SAMPLE_W-1:0] MIN_RST       = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] MAX_RST       = 16'sh8000;

    // full-scale magnitude, span = 32768 - dead_zone
    localparam logic [SAMPLE_W:0] FULL_SCALE = 17'd32768;

    // arithmetic widths
    localparam int MEAN_W     = 31;                    // mean of squares <= 2^30
    localparam int SCALE_SQ_W = 2 * SCALE_W;           // scale^2
    localparam int PROD_W     = MEAN_W + SCALE_SQ_W;   // scale^2 * mean
    localparam int RAD_W      = PROD_W + (PROD_W % 2);
    localparam int ROOT_W     = RAD_W / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    // handshake between the sequencer and a serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

@@ rtl/brlm_serial_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlm_serial_mul
// shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module brlm_serial_mul
    import brlm_pkg::*;
#(
    parameter int A_W = 31,
    parameter int B_W = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic [A_W+B_W-1:0]   o_product,
    output t_unit_sts            o_sts
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   r_acc;
    logic [P_W-1:0]   r_a;
    logic [B_W-1:0]   r_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [P_W-1:0]   n_acc;

    assign n_acc = r_b[0] ? (r_acc + r_a) : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= P_W'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_a   <= {r_a[P_W-2:0], 1'b0};
            r_b   <= {1'b0, r_b[B_W-1:1]};
        end
    end

    assign o_product  = r_acc;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

@@ rtl/brlm_serial_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlm_serial_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module brlm_serial_div
    import brlm_pkg::*;
#(
    parameter int N_W = 46,
    parameter int D_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [N_W-1:0]   i_num,
    input  logic [D_W-1:0]   i_den,
    output logic [N_W-1:0]   o_quot,
    output t_unit_sts        o_sts
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   r_num;    // dividend shifts out, quotient shifts in
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [D_W:0]     w_trial;
    logic [D_W:0]     w_diff;
    logic             w_ge;
    logic [D_W-1:0]   n_rem;

    always_comb begin
        w_trial = {r_rem, r_num[N_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[N_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_quot     = r_num;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

@@ rtl/block_rms_level_meter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_rms_level_meter
// block rms level meter with dead zone, min, max and zero count
// ----------------------------------------------------------------------------
// A sample that does not close a block is handled in full before the next
// sample is taken: the square of the dead-zone shrunk magnitude is formed
// by a shift-add multiplier pass, then added to the accumulator and the
// block length checked. The sample that closes a block adds the end-of-block
// math: a mean divide and the two multiplier passes for scale^2 and
// scale^2*mean on the shared bit-serial units, an integer square root worked
// bit-serially in the sequencer and a second divide by the span. A closing
// sample is done once its result has moved into the output register; new
// samples are taken while it waits there, and the block stalls only if a
// second result is ready before the first is taken. No clearing pass is
// needed after reset. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
`include "block_rms_level_meter_macros.svh"

module block_rms_level_meter
    import brlm_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_W-1:0]    i_sample,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [LEVEL_W-1:0]            o_level,
    output logic signed [SAMPLE_W-1:0]    o_block_min,
    output logic signed [SAMPLE_W-1:0]    o_block_max,
    output logic [ZCOUNT_W-1:0]           o_zero_count,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    // accumulator holds up to 2^COUNT_BITS-1 squares of at most 2^30
    localparam int SUM_W  = MEAN_W - 1 + COUNT_BITS;
    // divisor is either the sample count or the 16-bit span
    localparam int DIV_DW = (COUNT_BITS > BLOCK_W) ? COUNT_BITS : BLOCK_W;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SQUARE   = 4'd1;
    localparam logic [3:0] S_CHECK    = 4'd2;
    localparam logic [3:0] S_MEAN     = 4'd3;
    localparam logic [3:0] S_SCALE_SQ = 4'd4;
    localparam logic [3:0] S_TARGET   = 4'd5;
    localparam logic [3:0] S_ROOT     = 4'd6;
    localparam logic [3:0] S_SPAN     = 4'd7;
    localparam logic [3:0] S_OUTPUT   = 4'd8;

    // configuration registers
    logic [BLOCK_W-1:0]           r_block_size;
    logic [SCALE_W-1:0]           r_scale;
    logic [DZ_W-1:0]              r_dead_zone;

    // block state
    logic [3:0]                   r_state;
    logic [SUM_W-1:0]             r_sum;
    logic [COUNT_BITS-1:0]        r_count;
    logic signed [SAMPLE_W-1:0]   r_run_min;
    logic signed [SAMPLE_W-1:0]   r_run_max;
    logic [ZCOUNT_W-1:0]          r_zeros;

    // end-of-block working registers
    logic [MEAN_W-1:0]            r_mean;
    logic [RAD_W-1:0]             r_rad;
    logic [ROOT_W+1:0]            r_sq_rem;
    logic [ROOT_W-1:0]            r_root;
    logic [ROOT_CNT_W-1:0]        r_iter;
    logic [LEVEL_W-1:0]           r_level;

    // serial unit operands
    logic                         r_mul_start;
    logic [MEAN_W-1:0]            r_mul_a;
    logic [SCALE_SQ_W-1:0]        r_mul_b;
    logic                         r_div_start;
    logic [SUM_W-1:0]             r_div_num;
    logic [DIV_DW-1:0]            r_div_den;

    // output register
    logic                         r_out_valid;
    logic [LEVEL_W-1:0]           r_out_level;
    logic signed [SAMPLE_W-1:0]   r_out_min;
    logic signed [SAMPLE_W-1:0]   r_out_max;
    logic [ZCOUNT_W-1:0]          r_out_zeros;

    logic [PROD_W-1:0]            w_mul_product;
    t_unit_sts                    w_mul_sts;
    logic [SUM_W-1:0]             w_div_quot;
    t_unit_sts                    w_div_sts;

    logic                         w_in_fire;
    logic                         w_out_free;
    logic                         w_load_out;
    logic [SAMPLE_W:0]            w_abs;
    logic [SAMPLE_W:0]            w_shrunk;
    logic                         w_in_zone;
    logic [SAMPLE_W-1:0]          n_mag;
    logic [BLOCK_W-1:0]           w_limit;
    logic                         w_block_end;
    logic [BLOCK_W-1:0]           w_span;
    logic [ROOT_W+1:0]            w_sq_shift;
    logic [ROOT_W+1:0]            w_sq_trial;
    logic                         w_sq_ge;
    logic [ROOT_W+1:0]            n_sq_rem;
    logic [ROOT_W-1:0]            n_root;

    // ------------------------------------------------------------------
    // shared bit-serial units
    // ------------------------------------------------------------------
    brlm_serial_mul #(
        .A_W (MEAN_W),
        .B_W (SCALE_SQ_W)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_start),
        .i_a       (r_mul_a),
        .i_b       (r_mul_b),
        .o_product (w_mul_product),
        .o_sts     (w_mul_sts)
    );

    brlm_serial_div #(
        .N_W (SUM_W),
        .D_W (DIV_DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_quot  (w_div_quot),
        .o_sts   (w_div_sts)
    );

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_load_out  = (r_state == S_OUTPUT) && w_out_free;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    always_comb begin
        // magnitude of the incoming sample, then the dead-zone shrink
        w_abs     = i_sample[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {1'b1, i_sample})
                                         : {1'b0, i_sample};
        w_in_zone = (w_abs <= {2'b00, r_dead_zone});
        w_shrunk  = w_abs - {2'b00, r_dead_zone};
        n_mag     = w_in_zone ? '0 : w_shrunk[SAMPLE_W-1:0];

        // a zero block size behaves as one
        w_limit     = (r_block_size == '0) ? BLOCK_W'(1) : r_block_size;
        w_block_end = (DIV_DW'(r_count) >= DIV_DW'(w_limit)) || (r_count == '1);

        w_span = BLOCK_W'(FULL_SCALE - {2'b00, r_dead_zone});

        // one digit of the integer square root, two radicand bits a step
        w_sq_shift = {r_sq_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
        w_sq_trial = {r_root, 2'b01};
        w_sq_ge    = (w_sq_shift >= w_sq_trial);
        n_sq_rem   = w_sq_ge ? (w_sq_shift - w_sq_trial) : w_sq_shift;
        n_root     = {r_root[ROOT_W-2:0], w_sq_ge};
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BLOCK_SIZE_RST;
            r_scale      <= SCALE_RST;
            r_dead_zone  <= DEAD_ZONE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_BLOCK_SIZE: begin
                    r_block_size <= i_cfg_data[BLOCK_W-1:0];
                end
                REG_SCALE: begin
                    r_scale <= i_cfg_data[SCALE_W-1:0];
                end
                REG_DEAD_ZONE: begin
                    r_dead_zone <= i_cfg_data[DZ_W-1:0];
                end
                default: begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer and block state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_run_min   <= MIN_RST;
            r_run_max   <= MAX_RST;
            r_zeros     <= '0;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        // min, max and counters settle at the transaction
                        if (i_sample < r_run_min) begin
                            r_run_min <= i_sample;
                        end
                        if (i_sample > r_run_max) begin
                            r_run_max <= i_sample;
                        end
                        if (w_in_zone) begin
                            r_zeros <= r_zeros + 1'b1;
                        end
                        r_count     <= r_count + 1'b1;
                        r_mul_a     <= MEAN_W'(n_mag);
                        r_mul_b     <= SCALE_SQ_W'(n_mag);
                        r_mul_start <= 1'b1;
                        r_state     <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    if (w_mul_sts.done) begin
                        r_sum   <= r_sum + SUM_W'(w_mul_product);
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_block_end) begin
                        r_div_num   <= r_sum;
                        r_div_den   <= DIV_DW'(r_count);
                        r_div_start <= 1'b1;
                        r_state     <= S_MEAN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MEAN: begin
                    if (w_div_sts.done) begin
                        r_mean      <= w_div_quot[MEAN_W-1:0];
                        r_mul_a     <= MEAN_W'(r_scale);
                        r_mul_b     <= SCALE_SQ_W'(r_scale);
                        r_mul_start <= 1'b1;
                        r_state     <= S_SCALE_SQ;
                    end
                end
                S_SCALE_SQ: begin
                    if (w_mul_sts.done) begin
                        r_mul_a     <= r_mean;
                        r_mul_b     <= w_mul_product[SCALE_SQ_W-1:0];
                        r_mul_start <= 1'b1;
                        r_state     <= S_TARGET;
                    end
                end
                S_TARGET: begin
                    if (w_mul_sts.done) begin
                        r_rad    <= RAD_W'(w_mul_product);
                        r_sq_rem <= '0;
                        r_root   <= '0;
                        r_iter   <= '0;
                        r_state  <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    r_rad    <= {r_rad[RAD_W-3:0], 2'b00};
                    r_sq_rem <= n_sq_rem;
                    r_root   <= n_root;
                    r_iter   <= r_iter + 1'b1;
                    if (r_iter == ROOT_CNT_W'(ROOT_W - 1)) begin
                        // floor(isqrt(target) / span) is the largest level
                        r_div_num   <= SUM_W'(n_root);
                        r_div_den   <= DIV_DW'(w_span);
                        r_div_start <= 1'b1;
                        r_state     <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    if (w_div_sts.done) begin
                        if (|w_div_quot[SUM_W-1:LEVEL_W]) begin
                            r_level <= LEVEL_MAX;
                        end else begin
                            r_level <= w_div_quot[LEVEL_W-1:0];
                        end
                        r_state <= S_OUTPUT;
                    end
                end
                S_OUTPUT: begin
                    if (w_out_free) begin
                        // result moves out, block state starts over
                        r_sum     <= '0;
                        r_count   <= '0;
                        r_run_min <= MIN_RST;
                        r_run_max <= MAX_RST;
                        r_zeros   <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_level <= r_level;
            r_out_min   <= r_run_min;
            r_out_max   <= r_run_max;
            r_out_zeros <= r_zeros;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_level      = r_out_level;
    assign o_block_min  = r_out_min;
    assign o_block_max  = r_out_max;
    assign o_zero_count = r_out_zeros;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `BRLM_ASSERT_NEXT(a_sample_starts_square, w_in_fire, r_mul_start && r_state == S_SQUARE, "sample transaction did not launch the squaring pass")
    `BRLM_ASSERT_NOW(a_units_exclusive, w_mul_sts.busy, !w_div_sts.busy, "multiplier and divider busy together")
    `BRLM_ASSERT_NOW(a_count_live, r_state != S_IDLE, r_count != '0, "block math running with an empty sample count")
    `BRLM_ASSERT_NOW(a_result_from_output_state, r_out_valid && !$past(r_out_valid), $past(r_state) == S_OUTPUT, "result appeared outside the output step")

endmodule

@@ verif/block_rms_level_meter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_rms_level_meter_checker
// watches all three channels, predicts each block reading and compares it
// ----------------------------------------------------------------------------
module block_rms_level_meter_checker
    import brlm_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [LEVEL_W-1:0]         i_level,
    input  logic signed [SAMPLE_W-1:0] i_block_min,
    input  logic signed [SAMPLE_W-1:0] i_block_max,
    input  logic [ZCOUNT_W-1:0]        i_zero_count,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output int                         o_mismatches,
    output int                         o_pending
);

    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [SAMPLE_W-1:0] lowest;
        logic [SAMPLE_W-1:0] highest;
        logic [ZCOUNT_W-1:0] zeros;
    } meter_reading_t;

    meter_reading_t readings_due[$];
    meter_reading_t oldest;

    // register copies
    logic [BLOCK_W-1:0] block_len;
    logic [SCALE_W-1:0] full_scale_level;
    logic [DZ_W-1:0]    dead_zone_mag;

    // running block state
    logic [63:0]                energy_sum;
    logic [COUNT_BITS-1:0]      samples_in_block;
    logic signed [SAMPLE_W-1:0] block_low;
    logic signed [SAMPLE_W-1:0] block_high;
    logic [ZCOUNT_W-1:0]        zeros_in_block;

    int mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_total++;
    endtask

    task automatic clear_block();
        energy_sum       = '0;
        samples_in_block = '0;
        block_low        = MIN_RST;
        block_high       = MAX_RST;
        zeros_in_block   = '0;
    endtask

    // largest root with (root * span)^2 <= scale^2 * mean, bit by bit from the top
    function automatic logic [LEVEL_W-1:0] rms_level(input logic [63:0] mean_sq,
                                                     input logic [63:0] span);
        logic [63:0] target;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] scaled;
        target = {54'd0, full_scale_level} * {54'd0, full_scale_level} * mean_sq;
        root   = '0;
        for (int b = 10; b >= 0; b--) begin
            trial  = root | (64'd1 << b);
            scaled = trial * span;
            if (scaled * scaled <= target)
                root = trial;
        end
        return (root > 64'd1023) ? LEVEL_MAX : root[LEVEL_W-1:0];
    endfunction

    task automatic take_sample(input logic signed [SAMPLE_W-1:0] s);
        int             value;
        int             dz;
        int             mag;
        logic [63:0]    sq;
        logic [63:0]    span;
        logic [BLOCK_W-1:0] limit;
        meter_reading_t rd;
        value = s;
        dz    = dead_zone_mag;
        if (s < block_low)
            block_low = s;
        if (s > block_high)
            block_high = s;
        if (value <= dz && value >= -dz) begin
            mag = 0;
            zeros_in_block = zeros_in_block + 1'b1;
        end else begin
            mag = ((value < 0) ? -value : value) - dz;
        end
        sq               = mag;
        energy_sum       = energy_sum + sq * sq;
        samples_in_block = samples_in_block + 1'b1;
        limit = (block_len == '0) ? BLOCK_W'(1) : block_len;
        if (samples_in_block >= limit || samples_in_block == COUNT_FULL) begin
            span       = FULL_SCALE;
            span       = span - dead_zone_mag;
            rd.level   = rms_level(energy_sum / samples_in_block, span);
            rd.lowest  = block_low;
            rd.highest = block_high;
            rd.zeros   = zeros_in_block;
            readings_due.push_back(rd);
            clear_block();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            block_len        = BLOCK_SIZE_RST;
            full_scale_level = SCALE_RST;
            dead_zone_mag    = DEAD_ZONE_RST;
            clear_block();
            readings_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_BLOCK_SIZE: block_len        = i_cfg_data[BLOCK_W-1:0];
                    REG_SCALE:      full_scale_level = i_cfg_data[SCALE_W-1:0];
                    REG_DEAD_ZONE:  dead_zone_mag    = i_cfg_data[DZ_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                take_sample(i_sample);
            if (i_out_valid && i_out_ready) begin
                if (readings_due.size() == 0) begin
                    report_mismatch($sformatf("reading with none due: level %0d min %0d max %0d zeros %0d",
                                              i_level, i_block_min, i_block_max, i_zero_count));
                end else begin
                    oldest = readings_due.pop_front();
                    if (i_level !== oldest.level)
                        report_mismatch($sformatf("level %0d, expected %0d",
                                                  i_level, oldest.level));
                    if (i_block_min !== oldest.lowest)
                        report_mismatch($sformatf("block_min %0d, expected %0d",
                                                  i_block_min, $signed(oldest.lowest)));
                    if (i_block_max !== oldest.highest)
                        report_mismatch($sformatf("block_max %0d, expected %0d",
                                                  i_block_max, $signed(oldest.highest)));
                    if (i_zero_count !== oldest.zeros)
                        report_mismatch($sformatf("zero_count %0d, expected %0d",
                                                  i_zero_count, oldest.zeros));
                end
            end
        end
        o_pending <= readings_due.size();
    end

endmodule

@@ verif/block_rms_level_meter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_rms_level_meter_test
// directed and random sample streams through the rms level meter
// ----------------------------------------------------------------------------
// The top only makes stimulus: register writes while the meter is idle,
// sample transactions with random gaps, and a result side that stalls at
// random and once for a long stretch. The checker beside the meter predicts
// every block reading and counts mismatches; the top gives the verdict.
// ----------------------------------------------------------------------------
module block_rms_level_meter_test;
    import brlm_pkg::*;

    localparam int COUNT_BITS     = 16;
    localparam int RESET_CYCLES   = 9;
    localparam int ITEM_TARGET    = 1750;
    localparam int DRAIN_CYCLES   = 400;
    localparam int HOLD_CYCLES    = 1500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int IDLE_PERCENT   = 15;
    // window of items with no idling on either side
    localparam int STEADY_FIRST   = 900;
    localparam int STEADY_LAST    = 1200;

    // register selection masks for program_meter
    localparam logic [2:0] SET_BLOCK = 3'b001 << REG_BLOCK_SIZE;
    localparam logic [2:0] SET_SCALE = 3'b001 << REG_SCALE;
    localparam logic [2:0] SET_DZ    = 3'b001 << REG_DEAD_ZONE;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // sample channel
    logic                       in_valid  = 1'b0;
    logic signed [SAMPLE_W-1:0] in_sample = '0;
    logic                       in_ready;
    // result channel
    logic                       out_ready = 1'b0;
    logic                       out_valid;
    logic [LEVEL_W-1:0]         level;
    logic signed [SAMPLE_W-1:0] block_min;
    logic signed [SAMPLE_W-1:0] block_max;
    logic [ZCOUNT_W-1:0]        zero_count;
    // configuration channel
    logic                       cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;
    logic                       cfg_ready;

    int mismatches;
    int readings_pending;
    int sent_count   = 0;
    int stall_cycles = 0;

    // dead zone currently programmed, steers samples toward its edges
    logic [DZ_W-1:0] dead_zone_now = DEAD_ZONE_RST;

    logic steady    = 1'b0;
    logic want_hold = 1'b0;
    logic hold_done = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    block_rms_level_meter #(
        .COUNT_BITS (COUNT_BITS)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_sample     (in_sample),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_level      (level),
        .o_block_min  (block_min),
        .o_block_max  (block_max),
        .o_zero_count (zero_count),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    block_rms_level_meter_checker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_sample     (in_sample),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_level      (level),
        .i_block_min  (block_min),
        .i_block_max  (block_max),
        .i_zero_count (zero_count),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (readings_pending)
    );

    // one register write transaction; valid is left high for a following write
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // write the selected registers back to back, then drop valid once
    task automatic program_meter(input logic [2:0] which,
                                 input logic [BLOCK_W-1:0] bs,
                                 input logic [SCALE_W-1:0] sc,
                                 input logic [DZ_W-1:0] dz);
        if (which[REG_BLOCK_SIZE])
            write_register(REG_BLOCK_SIZE, bs);
        if (which[REG_SCALE])
            write_register(REG_SCALE, sc);
        if (which[REG_DEAD_ZONE]) begin
            write_register(REG_DEAD_ZONE, dz);
            dead_zone_now = dz;
        end
        cfg_valid <= 1'b0;
    endtask

    // one sample transaction, optionally preceded by an idle gap;
    // valid stays high into the next call unless a gap is taken
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 30))
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    // stop offering, wait for every due reading, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (readings_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // mix of full-range noise, dead-zone edges, the two rails and small values around zero
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input logic [DZ_W-1:0] dz);
        int k;
        int v;
        k = $urandom_range(0, 99);
        if (k < 55) begin
            v = $urandom_range(0, 65535);
        end else if (k < 85) begin
            // just inside, on, or just outside the dead zone, either sign
            v = dz + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1) == 1)
                v = -v;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
        end else if (k < 91) begin
            v = 32767;
        end else if (k < 97) begin
            v = -32768;
        end else begin
            v = $urandom_range(0, 16);
            v = v - 8;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // result side: random stalls, none inside the steady window, and one
    // long hold-off so the meter fills up and pushes back on its input
    initial begin : result_sink
        int held;
        forever begin
            @(posedge clk);
            if (want_hold && !hold_done) begin
                out_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_done = 1'b1;
            end else begin
                out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // watchdog: cycles in a row with no transaction on any channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int              k;
        int              n;
        logic [2:0]      which;
        logic [BLOCK_W-1:0] bs;
        logic [SCALE_W-1:0] sc;
        logic [DZ_W-1:0]    dz;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: block of 11025, so these only accumulate
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        settle();

        // shrink the block below what is already counted: next sample closes it
        program_meter(SET_BLOCK, 16'd3, SCALE_RST, DEAD_ZONE_RST);
        send_sample(16'sh0000);
        settle();

        // block size zero acts as one, full-scale level at the rails
        program_meter(SET_BLOCK | SET_SCALE, 16'd0, 10'd1000, DEAD_ZONE_RST);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        settle();

        // widest dead zone with zero scale; only the negative rail escapes it
        program_meter(SET_SCALE | SET_DZ, 16'd0, 10'd0, 15'd32767);
        send_sample(16'sh8000);
        settle();

        // same dead zone, span of one, full scale
        program_meter(SET_BLOCK | SET_SCALE, 16'd4, 10'd1000, 15'd32767);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8001);
        send_sample(16'sh0005);
        settle();

        // samples on and around both edges of a small dead zone
        program_meter(SET_BLOCK | SET_SCALE | SET_DZ, 16'd8, 10'd7, 15'd100);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        send_sample(16'sd101);
        send_sample(-16'sd101);
        send_sample(16'sd99);
        send_sample(-16'sd99);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        settle();

        // longest block, then cut short mid-block
        program_meter(SET_BLOCK | SET_DZ, 16'hFFFF, 10'd7, 15'd0);
        send_sample(16'sd1234);
        send_sample(-16'sd4321);
        send_sample(16'sd0);
        settle();
        program_meter(SET_BLOCK | SET_SCALE, 16'd2, 10'd1, 15'd0);
        send_sample(16'sd2000);
        settle();

        // every sample closes a block while the result side holds off
        program_meter(SET_BLOCK | SET_SCALE, 16'd1, 10'd500, 15'd0);
        want_hold = 1'b1;
        repeat (30)
            send_sample(pick_sample(dead_zone_now));
        settle();

        // random phases: new settings, a burst of samples, drain
        while (sent_count < ITEM_TARGET) begin
            which = 3'($urandom_range(0, 7));
            k = $urandom_range(0, 99);
            if (k < 5)
                bs = '0;
            else if (k < 15)
                bs = 16'd1;
            else if (k < 80)
                bs = 16'($urandom_range(2, 12));
            else if (k < 95)
                bs = 16'($urandom_range(13, 200));
            else
                bs = 16'hFFFF;
            k = $urandom_range(0, 99);
            if (k < 10)
                sc = '0;
            else if (k < 20)
                sc = 10'd1000;
            else
                sc = 10'($urandom_range(1, 1000));
            k = $urandom_range(0, 99);
            if (k < 15)
                dz = '0;
            else if (k < 25)
                dz = 15'd32767;
            else if (k < 55)
                dz = 15'($urandom_range(1, 64));
            else if (k < 80)
                dz = 15'($urandom_range(65, 4000));
            else
                dz = 15'($urandom_range(4001, 32766));
            program_meter(which, bs, sc, dz);
            n = $urandom_range(8, 60);
            repeat (n) begin
                steady = (sent_count >= STEADY_FIRST) && (sent_count < STEADY_LAST);
                send_sample(pick_sample(dead_zone_now));
            end
            steady = 1'b0;
            settle();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/brlm_pkg.sv
rtl/brlm_serial_mul.sv
rtl/brlm_serial_div.sv
rtl/block_rms_level_meter.sv
verif/block_rms_level_meter_checker.sv
verif/block_rms_level_meter_test.sv
